// ===== sv/hpal_pkg.sv =====
// ----------------------------------------------------------------------------
// hpal_pkg
// Shared types and constants of the hall pair angle lookup: action codes,
// register indexes, the command classes passed from front to back and the
// state types of the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hpal_pkg;

  // Default geometry of the level tables and width of the sample fields.
  localparam int TABLE_DEPTH    = 64;
  localparam int SAMPLE_BITS    = 12;
  localparam int FIELD_SAMPLE_W = 12;
  localparam int FIELD_ENTRY_W  = 6;
  localparam int FIELD_COUNT_W  = 7;
  localparam int CODE_W         = 8;
  localparam int STEP_W         = 8;
  localparam int ANGLE_W        = 14;
  localparam int FOUND_W        = 6;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_ROWS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_COLUMNS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_ROWS    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_COLUMNS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_GAIN     = 3'd4;

  localparam logic [STEP_W-1:0] STEP_GAIN_RESET = 8'd1;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_WR_ROW  = 2'd0;
  localparam logic [1:0] ACT_WR_COL  = 2'd1;
  localparam logic [1:0] ACT_WR_GRID = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Division by seven of a 16-bit product: floor(x * 74899 / 2^19) is exact
  // for every x below 2^16.
  localparam int PROD_W  = CODE_W + STEP_W;
  localparam int RECIP_W = 17;
  localparam int QUOT_W  = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV7_RECIP = 17'd74899;
  localparam int DIV7_SHIFT = 19;

  // Command classes produced by the front end.
  typedef enum logic [2:0] {
    K_WR_ROW,
    K_WR_COL,
    K_WR_GRID,
    K_QUERY,
    K_NULL
  } hpal_kind_t;

  typedef struct packed {
    hpal_kind_t kind;
    logic       motor;
  } hpal_ctrl_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_RUN,
    SC_DONE
  } hpal_scan_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_GRID,
    BK_MUL,
    BK_OUT
  } hpal_back_state_t;

endpackage

`default_nettype wire

// ===== sv/hpal_front.sv =====
// ----------------------------------------------------------------------------
// hpal_front
// Accepts input transactions, drops writes that fall outside the tables and
// classifies queries, clamping the table counts of the selected motor.
// ----------------------------------------------------------------------------
`default_nettype none

module hpal_front #(
  parameter int TABLE_DEPTH = hpal_pkg::TABLE_DEPTH,
  parameter int LEVEL_W     = hpal_pkg::FIELD_SAMPLE_W,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                                      start,
  input  wire logic                                      full,
  input  wire logic [1:0]                                action,
  input  wire logic                                      motor_select,
  input  wire logic [hpal_pkg::FIELD_ENTRY_W-1:0]        entry_row,
  input  wire logic [hpal_pkg::FIELD_ENTRY_W-1:0]        entry_column,
  input  wire logic [hpal_pkg::FIELD_SAMPLE_W-1:0]       level_value,
  input  wire logic [hpal_pkg::CODE_W-1:0]               angle_code,
  input  wire logic [hpal_pkg::FIELD_SAMPLE_W-1:0]       first_sample,
  input  wire logic [hpal_pkg::FIELD_SAMPLE_W-1:0]       second_sample,
  input  wire logic [hpal_pkg::FIELD_COUNT_W-1:0]        left_rows,
  input  wire logic [hpal_pkg::FIELD_COUNT_W-1:0]        left_columns,
  input  wire logic [hpal_pkg::FIELD_COUNT_W-1:0]        right_rows,
  input  wire logic [hpal_pkg::FIELD_COUNT_W-1:0]        right_columns,
  output logic                                           busy,
  output logic                                           push,
  output hpal_pkg::hpal_ctrl_t                           ctrl,
  output logic [IDX_W-1:0]                               row_idx,
  output logic [IDX_W-1:0]                               col_idx,
  output logic [LEVEL_W-1:0]                             data,
  output logic [LEVEL_W-1:0]                             s0,
  output logic [LEVEL_W-1:0]                             s1,
  output logic [CNT_W-1:0]                               rows,
  output logic [CNT_W-1:0]                               cols
);

  localparam int EXT_W = ((IDX_W > hpal_pkg::FIELD_ENTRY_W) ? IDX_W
                          : hpal_pkg::FIELD_ENTRY_W) + 1;
  localparam int CE_W  = (CNT_W > hpal_pkg::FIELD_COUNT_W) ? CNT_W
                          : hpal_pkg::FIELD_COUNT_W;

  logic [EXT_W-1:0] row_ext, col_ext;
  logic             row_ok, col_ok, keep;
  logic [CE_W-1:0]  rows_ext, cols_ext;

  assign row_ext = EXT_W'(entry_row);
  assign col_ext = EXT_W'(entry_column);
  assign row_ok  = row_ext < EXT_W'(TABLE_DEPTH);
  assign col_ok  = col_ext < EXT_W'(TABLE_DEPTH);
  assign row_idx = row_ext[IDX_W-1:0];
  assign col_idx = col_ext[IDX_W-1:0];

  // Counts above the table depth saturate.
  assign rows_ext = CE_W'(motor_select ? right_rows : left_rows);
  assign cols_ext = CE_W'(motor_select ? right_columns : left_columns);
  assign rows = (rows_ext > CE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(rows_ext);
  assign cols = (cols_ext > CE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cols_ext);

  assign s0 = first_sample[LEVEL_W-1:0];
  assign s1 = second_sample[LEVEL_W-1:0];

  always_comb begin
    ctrl.motor = motor_select;
    data       = level_value[LEVEL_W-1:0];
    unique case (action)
      hpal_pkg::ACT_WR_ROW: begin
        ctrl.kind = hpal_pkg::K_WR_ROW;
        keep      = row_ok;
      end
      hpal_pkg::ACT_WR_COL: begin
        ctrl.kind = hpal_pkg::K_WR_COL;
        keep      = col_ok;
      end
      hpal_pkg::ACT_WR_GRID: begin
        ctrl.kind = hpal_pkg::K_WR_GRID;
        keep      = row_ok && col_ok;
        data      = LEVEL_W'(angle_code);
      end
      default: begin
        ctrl.kind = (rows == '0 || cols == '0) ? hpal_pkg::K_NULL : hpal_pkg::K_QUERY;
        keep      = 1'b1;
      end
    endcase
  end

  assign busy = full;
  assign push = start && !full && keep;

endmodule

`default_nettype wire

// ===== sv/hpal_queue.sv =====
// ----------------------------------------------------------------------------
// hpal_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hpal_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head
);

  localparam int QD   = hpal_pkg::QUEUE_DEPTH;
  localparam int PW   = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW   = $clog2(QD + 1);

  logic [WIDTH-1:0] slots [QD];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full       = (count == CW'(QD));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== sv/hpal_scan.sv =====
// ----------------------------------------------------------------------------
// hpal_scan
// One level table (both motors) and its nearest-while-falling scan. The scan
// reads one entry per cycle and stops at the first entry that is not closer or at the last counted entry.
// ----------------------------------------------------------------------------
`default_nettype none

module hpal_scan #(
  parameter int TABLE_DEPTH = hpal_pkg::TABLE_DEPTH,
  parameter int LEVEL_W     = hpal_pkg::FIELD_SAMPLE_W,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [IDX_W:0]     wr_addr,
  input  wire logic [LEVEL_W-1:0] wr_data,
  input  wire logic               start,
  input  wire logic               motor,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic [LEVEL_W-1:0] sample,
  output logic                    done,
  output logic [IDX_W-1:0]        found
);

  localparam int MEM_D = 2 * TABLE_DEPTH;

  logic [LEVEL_W-1:0] levels [MEM_D];
  logic [LEVEL_W-1:0] rd_data;
  logic [IDX_W:0]     rd_addr;

  hpal_pkg::hpal_scan_state_t state, state_next;

  logic               motor_q, pend, take, stop;
  logic [CNT_W-1:0]   count_q, scan_i, entry;
  logic [LEVEL_W-1:0] sample_q, best_dist, lvl_diff;
  logic [IDX_W-1:0]   best;

  // The read issued once scan_i has reached count_q is never used, so the
  // low bits of scan_i can address the entry.
  assign rd_addr = {motor_q, scan_i[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      levels[wr_addr] <= wr_data;
    end
    rd_data <= levels[rd_addr];
  end

  // rd_data holds the entry issued in the previous cycle.
  assign entry    = scan_i - 1'b1;
  assign lvl_diff = (sample_q >= rd_data) ? sample_q - rd_data : rd_data - sample_q;
  assign take     = pend && ((scan_i == CNT_W'(1)) || (lvl_diff < best_dist));
  assign stop     = pend && (!take || (scan_i == count_q));

  always_comb begin
    state_next = state;
    unique case (state)
      hpal_pkg::SC_IDLE: if (start) state_next = hpal_pkg::SC_RUN;
      hpal_pkg::SC_RUN:  if (stop)  state_next = hpal_pkg::SC_DONE;
      hpal_pkg::SC_DONE: if (start) state_next = hpal_pkg::SC_RUN;
      default:           state_next = hpal_pkg::SC_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      hpal_pkg::SC_DONE: done = 1'b1;
      default:           done = 1'b0;
    endcase
  end

  assign found = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpal_pkg::SC_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        pend <= 1'b0;
      end else if (state == hpal_pkg::SC_RUN) begin
        pend <= !stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      motor_q  <= motor;
      count_q  <= count;
      sample_q <= sample;
      scan_i   <= '0;
    end else if (state == hpal_pkg::SC_RUN && !stop) begin
      scan_i <= scan_i + 1'b1;
    end
    if (take) begin
      best      <= entry[IDX_W-1:0];
      best_dist <= lvl_diff;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpal_back.sv =====
// ----------------------------------------------------------------------------
// hpal_back
// Carries out queued commands: table and grid writes, and queries that run
// both level scans side by side, read the grid and scale the code by the
// step gain over seven; a query with a zero count gives an invalid result.
// ----------------------------------------------------------------------------
`default_nettype none

module hpal_back #(
  parameter int TABLE_DEPTH = hpal_pkg::TABLE_DEPTH,
  parameter int LEVEL_W     = hpal_pkg::FIELD_SAMPLE_W,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [hpal_pkg::STEP_W-1:0]       step_gain,
  input  wire logic                              head_valid,
  input  wire hpal_pkg::hpal_ctrl_t              head_ctrl,
  input  wire logic [IDX_W-1:0]                  head_row,
  input  wire logic [IDX_W-1:0]                  head_col,
  input  wire logic [LEVEL_W-1:0]                head_data,
  input  wire logic [LEVEL_W-1:0]                head_s0,
  input  wire logic [LEVEL_W-1:0]                head_s1,
  input  wire logic [CNT_W-1:0]                  head_rows,
  input  wire logic [CNT_W-1:0]                  head_cols,
  output logic                                   pop,
  output logic                                   done,
  output logic [hpal_pkg::ANGLE_W-1:0]           angle,
  output logic [hpal_pkg::FOUND_W-1:0]           row_found,
  output logic [hpal_pkg::FOUND_W-1:0]           column_found,
  output logic                                   valid_res
);

  localparam int GRID_D = 2 * TABLE_DEPTH * TABLE_DEPTH;
  localparam int GA_W   = 1 + 2 * IDX_W;
  localparam int WIDE_W = (IDX_W > hpal_pkg::FOUND_W) ? IDX_W : hpal_pkg::FOUND_W;

  hpal_pkg::hpal_back_state_t state, state_next;

  logic                           row_we, col_we, grid_we, scan_start;
  logic                           row_done, col_done;
  logic [IDX_W-1:0]               row_idx, col_idx;
  logic [hpal_pkg::CODE_W-1:0]    grid [GRID_D];
  logic [hpal_pkg::CODE_W-1:0]    grid_q;
  logic [GA_W-1:0]                grid_waddr, grid_raddr;
  logic                           motor_q;
  logic [hpal_pkg::PROD_W-1:0]    prod;
  logic [hpal_pkg::QUOT_W-1:0]    quot_full;
  logic [WIDE_W-1:0]              row_wide, col_wide;

  hpal_scan #(.TABLE_DEPTH(TABLE_DEPTH), .LEVEL_W(LEVEL_W)) u_row_scan (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (row_we),
    .wr_addr ({head_ctrl.motor, head_row}),
    .wr_data (head_data),
    .start   (scan_start),
    .motor   (head_ctrl.motor),
    .count   (head_rows),
    .sample  (head_s0),
    .done    (row_done),
    .found   (row_idx)
  );

  hpal_scan #(.TABLE_DEPTH(TABLE_DEPTH), .LEVEL_W(LEVEL_W)) u_col_scan (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (col_we),
    .wr_addr ({head_ctrl.motor, head_col}),
    .wr_data (head_data),
    .start   (scan_start),
    .motor   (head_ctrl.motor),
    .count   (head_cols),
    .sample  (head_s1),
    .done    (col_done),
    .found   (col_idx)
  );

  assign grid_waddr = {head_ctrl.motor, head_row, head_col};
  assign grid_raddr = {motor_q, row_idx, col_idx};

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid[grid_waddr] <= head_data[hpal_pkg::CODE_W-1:0];
    end
    grid_q <= grid[grid_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hpal_pkg::BK_IDLE: begin
        if (head_valid) begin
          if (head_ctrl.kind == hpal_pkg::K_QUERY) begin
            state_next = hpal_pkg::BK_SCAN;
          end else if (head_ctrl.kind == hpal_pkg::K_NULL) begin
            state_next = hpal_pkg::BK_OUT;
          end
        end
      end
      hpal_pkg::BK_SCAN: if (row_done && col_done) state_next = hpal_pkg::BK_GRID;
      hpal_pkg::BK_GRID: state_next = hpal_pkg::BK_MUL;
      hpal_pkg::BK_MUL:  state_next = hpal_pkg::BK_OUT;
      hpal_pkg::BK_OUT:  state_next = hpal_pkg::BK_IDLE;
      default:           state_next = hpal_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    done       = 1'b0;
    row_we     = 1'b0;
    col_we     = 1'b0;
    grid_we    = 1'b0;
    scan_start = 1'b0;
    unique case (state)
      hpal_pkg::BK_IDLE: begin
        pop = head_valid;
        unique case (head_ctrl.kind)
          hpal_pkg::K_WR_ROW:  row_we     = head_valid;
          hpal_pkg::K_WR_COL:  col_we     = head_valid;
          hpal_pkg::K_WR_GRID: grid_we    = head_valid;
          hpal_pkg::K_QUERY:   scan_start = head_valid;
          default: ;
        endcase
      end
      hpal_pkg::BK_OUT: done = 1'b1;
      default: ;
    endcase
  end

  assign quot_full = hpal_pkg::QUOT_W'(prod) * hpal_pkg::QUOT_W'(hpal_pkg::DIV7_RECIP);
  assign row_wide  = WIDE_W'(row_idx);
  assign col_wide  = WIDE_W'(col_idx);

  always_ff @(posedge clk) begin
    if (pop) begin
      motor_q <= head_ctrl.motor;
    end
    if (pop && head_ctrl.kind == hpal_pkg::K_NULL) begin
      angle        <= '0;
      row_found    <= '0;
      column_found <= '0;
      valid_res    <= 1'b0;
    end
    if (state == hpal_pkg::BK_GRID) begin
      prod <= hpal_pkg::PROD_W'(grid_q) * hpal_pkg::PROD_W'(step_gain);
    end
    if (state == hpal_pkg::BK_MUL) begin
      angle        <= quot_full[hpal_pkg::DIV7_SHIFT +: hpal_pkg::ANGLE_W];
      row_found    <= row_wide[hpal_pkg::FOUND_W-1:0];
      column_found <= col_wide[hpal_pkg::FOUND_W-1:0];
      valid_res    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpal_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_grid_after_scans: assert property (@(posedge clk) disable iff (rst)
    (state == hpal_pkg::BK_GRID) |-> (row_done && col_done))
    else $error("grid read before both scans finished");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (angle == '0 && row_found == '0 && column_found == '0))
    else $error("invalid result carries nonzero fields");

endmodule

`default_nettype wire

// ===== sv/hall_pair_angle_lookup.sv =====
// ----------------------------------------------------------------------------
// hall_pair_angle_lookup
// Converts a pair of hall-sensor samples of one of two motors into a rotor
// angle through per-motor level tables and an angle grid loaded by writes.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   --------  -------------------  ----------------------------------------
//   input     start / busy         action, motor_select, entry_row,
//                                  entry_column, level_value, angle_code,
//                                  first_sample, second_sample
//   result    done (1-cycle pulse) angle, row_found, column_found, valid_res
//   config    cfg_write            cfg_index, cfg_data
//
// A transaction is taken at every clock edge where start is high and busy is
// low. The front end classifies it, drops a write that falls outside the
// tables and places the rest in a two-entry command queue; busy is high only
// while that queue is full. Table and grid writes are stored as they leave
// the queue and produce no result. A query whose selected counts are both
// nonzero scans the row and column level tables in parallel, one entry per
// cycle each, then reads the grid and scales the code. The single read port
// of each level table sets this rate. A query with a zero count goes straight
// to the output state and returns an invalid result.
// Reset (rst, synchronous) empties the queue, idles the back end and loads
// the register defaults; table and grid contents are kept, not cleared.
// The receiver cannot stall: each result is shown while done is high and
// stays on its ports until the next result replaces it.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_pair_angle_lookup #(
  parameter int TABLE_DEPTH = hpal_pkg::TABLE_DEPTH,
  parameter int SAMPLE_BITS = hpal_pkg::SAMPLE_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Input transactions.
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            action,
  input  wire logic                                  motor_select,
  input  wire logic [hpal_pkg::FIELD_ENTRY_W-1:0]    entry_row,
  input  wire logic [hpal_pkg::FIELD_ENTRY_W-1:0]    entry_column,
  input  wire logic [hpal_pkg::FIELD_SAMPLE_W-1:0]   level_value,
  input  wire logic [hpal_pkg::CODE_W-1:0]           angle_code,
  input  wire logic [hpal_pkg::FIELD_SAMPLE_W-1:0]   first_sample,
  input  wire logic [hpal_pkg::FIELD_SAMPLE_W-1:0]   second_sample,
  // Results.
  output logic                                       done,
  output logic [hpal_pkg::ANGLE_W-1:0]               angle,
  output logic [hpal_pkg::FOUND_W-1:0]               row_found,
  output logic [hpal_pkg::FOUND_W-1:0]               column_found,
  output logic                                       valid_res,
  // Configuration writes.
  input  wire logic                                  cfg_write,
  input  wire logic [hpal_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [hpal_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Only the low SAMPLE_BITS bits of a sample or level take part, and the
  // fields themselves are 12 bits wide, so storage needs the smaller of both.
  localparam int LEVEL_W = (SAMPLE_BITS < hpal_pkg::FIELD_SAMPLE_W) ? SAMPLE_BITS
                           : hpal_pkg::FIELD_SAMPLE_W;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int CTRL_W  = $bits(hpal_pkg::hpal_ctrl_t);
  localparam int CMD_W   = CTRL_W + 2 * IDX_W + 3 * LEVEL_W + 2 * CNT_W;

  // Configuration registers.
  logic [hpal_pkg::FIELD_COUNT_W-1:0] left_rows, left_columns;
  logic [hpal_pkg::FIELD_COUNT_W-1:0] right_rows, right_columns;
  logic [hpal_pkg::STEP_W-1:0]        step_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_rows     <= '0;
      left_columns  <= '0;
      right_rows    <= '0;
      right_columns <= '0;
      step_gain     <= hpal_pkg::STEP_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        hpal_pkg::REG_LEFT_ROWS:     left_rows     <= cfg_data[hpal_pkg::FIELD_COUNT_W-1:0];
        hpal_pkg::REG_LEFT_COLUMNS:  left_columns  <= cfg_data[hpal_pkg::FIELD_COUNT_W-1:0];
        hpal_pkg::REG_RIGHT_ROWS:    right_rows    <= cfg_data[hpal_pkg::FIELD_COUNT_W-1:0];
        hpal_pkg::REG_RIGHT_COLUMNS: right_columns <= cfg_data[hpal_pkg::FIELD_COUNT_W-1:0];
        hpal_pkg::REG_STEP_GAIN:     step_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end outputs.
  logic                 push, full;
  hpal_pkg::hpal_ctrl_t f_ctrl;
  logic [IDX_W-1:0]     f_row, f_col;
  logic [LEVEL_W-1:0]   f_data, f_s0, f_s1;
  logic [CNT_W-1:0]     f_rows, f_cols;

  hpal_front #(.TABLE_DEPTH(TABLE_DEPTH), .LEVEL_W(LEVEL_W)) u_front (
    .start         (start),
    .full          (full),
    .action        (action),
    .motor_select  (motor_select),
    .entry_row     (entry_row),
    .entry_column  (entry_column),
    .level_value   (level_value),
    .angle_code    (angle_code),
    .first_sample  (first_sample),
    .second_sample (second_sample),
    .left_rows     (left_rows),
    .left_columns  (left_columns),
    .right_rows    (right_rows),
    .right_columns (right_columns),
    .busy          (busy),
    .push          (push),
    .ctrl          (f_ctrl),
    .row_idx       (f_row),
    .col_idx       (f_col),
    .data          (f_data),
    .s0            (f_s0),
    .s1            (f_s1),
    .rows          (f_rows),
    .cols          (f_cols)
  );

  // Command queue: one word per classified transaction.
  logic [CMD_W-1:0]     q_in, q_head;
  logic                 pop, head_valid;
  hpal_pkg::hpal_ctrl_t h_ctrl;
  logic [IDX_W-1:0]     h_row, h_col;
  logic [LEVEL_W-1:0]   h_data, h_s0, h_s1;
  logic [CNT_W-1:0]     h_rows, h_cols;

  assign q_in = {f_ctrl, f_row, f_col, f_data, f_s0, f_s1, f_rows, f_cols};
  assign {h_ctrl, h_row, h_col, h_data, h_s0, h_s1, h_rows, h_cols} = q_head;

  hpal_queue #(.WIDTH(CMD_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (q_in),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (q_head)
  );

  // Back end: tables, grid, scans and scaling.
  hpal_back #(.TABLE_DEPTH(TABLE_DEPTH), .LEVEL_W(LEVEL_W)) u_back (
    .clk          (clk),
    .rst          (rst),
    .step_gain    (step_gain),
    .head_valid   (head_valid),
    .head_ctrl    (h_ctrl),
    .head_row     (h_row),
    .head_col     (h_col),
    .head_data    (h_data),
    .head_s0      (h_s0),
    .head_s1      (h_s1),
    .head_rows    (h_rows),
    .head_cols    (h_cols),
    .pop          (pop),
    .done         (done),
    .angle        (angle),
    .row_found    (row_found),
    .column_found (column_found),
    .valid_res    (valid_res)
  );

endmodule

`default_nettype wire
